// ----- design/assert_macros.svh -----
// Assertion macros shared by the jitter block RTL.
// Clocked on clk_i, disabled while rst_ni is low; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif
`endif

// ----- design/lcgcsj_pkg.sv -----
// Types and constants for the LCG color and signal jitter block.
// No dependencies; used by the offset unit and the top level.
package lcgcsj_pkg;

  localparam int unsigned NUM_CH = 5;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  localparam logic [23:0] DRAW_FULL = 24'hFF_FFFF;
  localparam logic [23:0] DRAW_HALF = 24'h7F_FFFF;

  localparam logic signed [17:0] SIG_MAX   = 18'sd16384;
  localparam logic signed [17:0] SIG_MIN   = -18'sd16384;
  localparam logic signed [17:0] COLOR_MAX = 18'sd255;
  localparam logic signed [17:0] COLOR_MIN = 18'sd0;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_SEED         = 3'd1,
    REG_COLOR_SPAN   = 3'd2,
    REG_SMELL_AMOUNT = 3'd3,
    REG_TEMP_AMOUNT  = 3'd4,
    REG_ROTATE       = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CH_RED   = 3'd0,
    CH_GREEN = 3'd1,
    CH_BLUE  = 3'd2,
    CH_SMELL = 3'd3,
    CH_HEAT  = 3'd4
  } ch_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // request into the offset unit
  typedef struct packed {
    logic        vld;
    ch_e         idx;
    logic [23:0] draw;
    logic [14:0] amp;
  } op_t;

  // rounded offset out of the offset unit
  typedef struct packed {
    logic        vld;
    ch_e         idx;
    logic        neg;
    logic [15:0] mag;
  } res_t;

endpackage

// ----- design/lcgcsj_in_if.sv -----
// Input channel of the jitter block: one cell word with valid/ready.
// No dependencies.
interface lcgcsj_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic signed [15:0] smell_in;
  logic signed [15:0] heat_in;
  logic               liquid_hint;

  modport source (
    output valid, red_in, green_in, blue_in, smell_in, heat_in, liquid_hint,
    input  ready
  );
  modport sink (
    input  valid, red_in, green_in, blue_in, smell_in, heat_in, liquid_hint,
    output ready
  );
endinterface

// ----- design/lcgcsj_out_if.sv -----
// Output channel of the jitter block: one result word with valid/ready.
// No dependencies.
interface lcgcsj_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic signed [15:0] smell_out;
  logic signed [15:0] heat_out;

  modport source (
    output valid, red_out, green_out, blue_out, smell_out, heat_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, smell_out, heat_out,
    output ready
  );
endinterface

// ----- design/lcgcsj_offset.sv -----
// Shared offset unit: round_half_away((2r - M) * amp / M) in two stages.
// Depends on lcgcsj_pkg (op_t, res_t, draw constants).
module lcgcsj_offset import lcgcsj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  op_i,
  output res_t res_o
);

  logic [24:0] dbl;
  logic [24:0] mag;
  logic        neg;
  logic [39:0] acc_d;

  logic        a_vld_q;
  ch_e         a_idx_q;
  logic        a_neg_q;
  logic [39:0] a_acc_q;

  logic [15:0] quo_est;
  logic [24:0] rem;
  logic [15:0] quo;

  logic        b_vld_q;
  ch_e         b_idx_q;
  logic        b_neg_q;
  logic [15:0] b_mag_q;

  // stage A: |2r - M| * amp, plus (M - 1) / 2 for rounding
  always_comb begin
    dbl   = {op_i.draw, 1'b0};
    neg   = ~op_i.draw[23];
    mag   = neg ? ({1'b0, DRAW_FULL} - dbl) : (dbl - {1'b0, DRAW_FULL});
    acc_d = ({15'b0, mag} * {25'b0, op_i.amp}) + {16'b0, DRAW_HALF};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= op_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.vld) begin
      a_idx_q <= op_i.idx;
      a_neg_q <= neg;
      a_acc_q <= acc_d;
    end
  end

  // stage B: divide by 2^24 - 1; the estimate is low by at most one
  always_comb begin
    quo_est = a_acc_q[39:24];
    rem     = {1'b0, a_acc_q[23:0]} + {9'b0, quo_est};
    quo     = quo_est + {15'b0, (rem >= {1'b0, DRAW_FULL})};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_idx_q <= a_idx_q;
      b_neg_q <= a_neg_q;
      b_mag_q <= quo;
    end
  end

  assign res_o.vld = b_vld_q;
  assign res_o.idx = b_idx_q;
  assign res_o.neg = b_neg_q;
  assign res_o.mag = b_mag_q;

endmodule

// ----- design/lcg_color_signal_jitter.sv -----
// Channel   | Dir | Handshake    | Word
// cell_i    | in  | valid/ready  | red, green, blue, smell, heat, liquid hint
// cell_o    | out | valid/ready  | red, green, blue, smell, heat
// cfg_*     | in  | write enable | register index, 32-bit data
// Enabled: one cell at a time; five LCG steps (one 32x32 multiply per
// cycle) feed the two-stage offset unit, then one write-back per channel.
// Disabled: one cell at a time, passed through without generator steps.
// Reset clears control, the registers and sets the generator state to one.
// A result held on cell_o blocks the next result, not the next accept.
// Top level of the LCG color and signal jitter block.
// Depends on lcgcsj_pkg, lcgcsj_in_if, lcgcsj_out_if, lcgcsj_offset.
`include "assert_macros.svh"

module lcg_color_signal_jitter import lcgcsj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  lcgcsj_in_if.sink   cell_i,
  lcgcsj_out_if.source cell_o
);

  // configuration
  logic        enable_q;
  logic [7:0]  color_span_q;
  logic [14:0] smell_amt_q;
  logic [14:0] temp_amt_q;
  logic        rotate_q;
  logic [31:0] lcg_q;
  logic [31:0] lcg_d;

  // sequencer
  state_e      state_q;
  state_e      state_d;
  logic        accept;
  logic        load_out;
  logic        gen_act_q;
  ch_e         gen_idx_q;
  logic        iss_vld_q;
  ch_e         iss_idx_q;

  op_t         op;
  res_t        res;

  // working values
  logic signed [15:0] val_q [NUM_CH];
  logic               rot_q;
  logic signed [15:0] cur;
  logic signed [17:0] off;
  logic signed [17:0] sum;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic signed [15:0] wb;

  // output register
  logic               out_vld_q;
  logic [7:0]         red_q;
  logic [7:0]         green_q;
  logic [7:0]         blue_q;
  logic signed [15:0] smell_q;
  logic signed [15:0] heat_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      color_span_q <= '0;
      smell_amt_q  <= '0;
      temp_amt_q   <= '0;
      rotate_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:       enable_q     <= cfg_data_i[0];
        REG_COLOR_SPAN:   color_span_q <= cfg_data_i[7:0];
        REG_SMELL_AMOUNT: smell_amt_q  <= cfg_data_i[14:0];
        REG_TEMP_AMOUNT:  temp_amt_q   <= cfg_data_i[14:0];
        REG_ROTATE:       rotate_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- generator
  always_comb begin
    lcg_d = lcg_q;
    if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_SEED)) begin
      lcg_d = (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
    end else if (gen_act_q) begin
      lcg_d = lcg_q * LCG_MUL + LCG_INC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= 32'd1;
    end else begin
      lcg_q <= lcg_d;
    end
  end

  assign accept = cell_i.valid && cell_i.ready;

  // step the generator once per channel, red first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_act_q <= 1'b0;
      gen_idx_q <= CH_RED;
      iss_vld_q <= 1'b0;
      iss_idx_q <= CH_RED;
    end else begin
      iss_vld_q <= gen_act_q;
      iss_idx_q <= gen_idx_q;
      if (accept) begin
        gen_act_q <= enable_q;
        gen_idx_q <= CH_RED;
      end else if (gen_act_q) begin
        gen_idx_q <= ch_e'(gen_idx_q + 3'd1);
        if (gen_idx_q == CH_HEAT) begin
          gen_act_q <= 1'b0;
        end
      end
    end
  end

  // draw taken from the state left by the previous step
  always_comb begin
    op.vld  = iss_vld_q;
    op.idx  = iss_idx_q;
    op.draw = lcg_q[31:8];
    case (iss_idx_q)
      CH_SMELL: op.amp = smell_amt_q;
      CH_HEAT:  op.amp = temp_amt_q;
      default:  op.amp = {7'b0, color_span_q};
    endcase
  end

  lcgcsj_offset u_offset (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .res_o  (res)
  );

  // ------------------------------------------------------------ write-back
  always_comb begin
    cur = val_q[res.idx];
    off = res.neg ? -$signed({2'b0, res.mag}) : $signed({2'b0, res.mag});
    sum = {{2{cur[15]}}, cur} + off;
    if (res.idx inside {CH_RED, CH_GREEN, CH_BLUE}) begin
      lo = COLOR_MIN;
      hi = COLOR_MAX;
    end else begin
      lo = SIG_MIN;
      hi = SIG_MAX;
    end
    if (sum < lo) begin
      wb = lo[15:0];
    end else if (sum > hi) begin
      wb = hi[15:0];
    end else begin
      wb = sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q[CH_RED]   <= {8'b0, cell_i.red_in};
      val_q[CH_GREEN] <= {8'b0, cell_i.green_in};
      val_q[CH_BLUE]  <= {8'b0, cell_i.blue_in};
      val_q[CH_SMELL] <= cell_i.smell_in;
      val_q[CH_HEAT]  <= cell_i.heat_in;
      rot_q           <= enable_q && rotate_q && cell_i.liquid_hint;
    end else if (res.vld) begin
      val_q[res.idx] <= wb;
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = enable_q ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (res.vld && (res.idx == CH_HEAT)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || cell_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_i.ready = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      ST_IDLE: cell_i.ready = 1'b1;
      ST_RUN:  ;
      ST_DONE: load_out = !out_vld_q || cell_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (cell_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // rotate liquid colors on the way out
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      red_q   <= rot_q ? val_q[CH_GREEN][7:0] : val_q[CH_RED][7:0];
      green_q <= rot_q ? val_q[CH_BLUE][7:0]  : val_q[CH_GREEN][7:0];
      blue_q  <= rot_q ? val_q[CH_RED][7:0]   : val_q[CH_BLUE][7:0];
      smell_q <= val_q[CH_SMELL];
      heat_q  <= val_q[CH_HEAT];
    end
  end

  assign cell_o.valid     = out_vld_q;
  assign cell_o.red_out   = red_q;
  assign cell_o.green_out = green_q;
  assign cell_o.blue_out  = blue_q;
  assign cell_o.smell_out = smell_q;
  assign cell_o.heat_out  = heat_q;

  // ------------------------------------------------------------ assertions
  `ASSERT_CLK(a_res_in_run, res.vld |-> state_q == ST_RUN)
  `ASSERT_CLK(a_lcg_hold, (state_q != ST_RUN && !cfg_we_i) |=> $stable(lcg_q))
  `ASSERT_CLK(a_last_done, (res.vld && res.idx == CH_HEAT) |=> state_q == ST_DONE)
  `ASSERT_NEVER(a_gen_idle, gen_act_q && state_q != ST_RUN)

endmodule
